FILE: src/ec_host_port_backlight_mailbox_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the host port backlight mailbox
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef EC_HOST_PORT_BACKLIGHT_MAILBOX_CORE_DEFINES_SVH
`define EC_HOST_PORT_BACKLIGHT_MAILBOX_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EHBM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("ehbm assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define EHBM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("ehbm assertion failed");

`endif

FILE: src/ehbm_pkg.sv
// ----------------------------------------------------------------------------
// Host port backlight mailbox package
// Types, command codes and sizes shared by the mailbox modules.
// ----------------------------------------------------------------------------
package ehbm_pkg;

  localparam int RamDepth  = 256;
  localparam int RamAw     = $clog2(RamDepth);
  localparam int ZoneCount = 3;
  localparam int ColorW    = 24;

  // Host port command codes.
  localparam logic [7:0] CmdRead  = 8'h80;
  localparam logic [7:0] CmdWrite = 8'h81;

  // Status register bits.
  localparam logic [7:0] StatObf = 8'h01;
  localparam logic [7:0] StatIbf = 8'h02;

  // Mailbox layout in controller RAM.
  localparam logic [RamAw-1:0] AddrDoorbell = RamAw'(8'hF8);
  localparam logic [RamAw-1:0] AddrParam0   = RamAw'(8'hF9);
  localparam logic [RamAw-1:0] AddrParam1   = RamAw'(8'hFA);
  localparam logic [RamAw-1:0] AddrParam2   = RamAw'(8'hFB);
  localparam logic [RamAw-1:0] AddrParam3   = RamAw'(8'hFC);

  // Mailbox command and parameter codes.
  localparam logic [7:0] MbCmdPower     = 8'hC4;
  localparam logic [7:0] MbCmdSet       = 8'hCA;
  localparam logic [7:0] MbSelPower     = 8'h0C;
  localparam logic [7:0] MbPowerOn      = 8'h3F;
  localparam logic [7:0] MbPowerOff     = 8'h20;
  localparam logic [7:0] MbSelZoneBase  = 8'h03;
  localparam logic [7:0] MbSelLevel     = 8'h06;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RD_ADDR,
    PH_WR_ADDR,
    PH_WR_DATA
  } host_phase_e;

  typedef struct packed {
    logic       port_select;
    logic       func;
    logic [7:0] write_data;
  } host_req_t;

  typedef struct packed {
    logic             en;
    logic [RamAw-1:0] addr;
    logic [7:0]       data;
  } ram_wr_t;

  typedef struct packed {
    logic             en;
    logic [RamAw-1:0] addr;
  } ram_rd_t;

endpackage

FILE: src/ehbm_if.sv
// ----------------------------------------------------------------------------
// Host port backlight mailbox channel interfaces
// Request channel carrying host accesses and response channel carrying results.
// ----------------------------------------------------------------------------
interface ehbm_req_if;
  logic       valid;
  logic       ready;
  logic       port_select;
  logic       func;
  logic [7:0] write_data;

  modport source (output valid, output port_select, output func, output write_data,
                  input ready);
  modport sink   (input valid, input port_select, input func, input write_data,
                  output ready);
endinterface

interface ehbm_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        backlight_on;
  logic [7:0]  brightness;
  logic [23:0] zone0_color;
  logic [23:0] zone1_color;
  logic [23:0] zone2_color;

  modport source (output valid, output read_data, output backlight_on, output brightness,
                  output zone0_color, output zone1_color, output zone2_color,
                  input ready);
  modport sink   (input valid, input read_data, input backlight_on, input brightness,
                  input zone0_color, input zone1_color, input zone2_color,
                  output ready);
endinterface

FILE: src/ehbm_ram.sv
// ----------------------------------------------------------------------------
// Controller RAM
// Single write port, single registered read port; per-entry valid bits make
// never-written bytes read as zero after reset.
// ----------------------------------------------------------------------------
module ehbm_ram
  import ehbm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  ram_wr_t   wr_i,
  input  ram_rd_t   rd_i,
  output logic [7:0] rd_data_o
);

  logic [7:0]          mem [RamDepth];
  logic [RamDepth-1:0] valid_q;
  logic [7:0]          rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.addr] <= 1'b1;
    end
  end

  // The read register doubles as the output buffer, so it resets to zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_data_q <= '0;
    end else if (rd_i.en) begin
      rd_data_q <= valid_q[rd_i.addr] ? mem[rd_i.addr] : 8'h00;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/ehbm_host.sv
// ----------------------------------------------------------------------------
// Host port sequencer
// Decodes command and data port accesses, tracks the command phase and
// output-full flag, and issues RAM reads and writes.
// ----------------------------------------------------------------------------
module ehbm_host
  import ehbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  host_req_t  req_i,
  input  logic [7:0] obuf_i,
  output ram_wr_t    ram_wr_o,
  output ram_rd_t    ram_rd_o,
  output logic [7:0] read_data_o
);

  host_phase_e      phase_q, phase_d;
  logic [RamAw-1:0] addr_q, addr_d;
  logic             obf_q, obf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      addr_q  <= '0;
      obf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      addr_q  <= addr_d;
      obf_q   <= obf_d;
    end
  end

  always_comb begin
    phase_d       = phase_q;
    addr_d        = addr_q;
    obf_d         = obf_q;
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = addr_q;
    ram_wr_o.data = req_i.write_data;
    ram_rd_o.en   = 1'b0;
    ram_rd_o.addr = req_i.write_data[RamAw-1:0];
    read_data_o   = 8'h00;

    if (req_i.port_select) begin
      if (req_i.func) begin
        // A new command always abandons whatever sequence was open.
        unique case (req_i.write_data)
          CmdRead:  phase_d = PH_RD_ADDR;
          CmdWrite: phase_d = PH_WR_ADDR;
          default:  phase_d = PH_IDLE;
        endcase
      end else begin
        // Input-full never sets: the controller drains each byte at once.
        read_data_o = (obf_q ? StatObf : 8'h00) & ~StatIbf;
      end
    end else if (req_i.func) begin
      unique case (phase_q)
        PH_RD_ADDR: begin
          ram_rd_o.en = step_i;
          obf_d       = 1'b1;
          phase_d     = PH_IDLE;
        end
        PH_WR_ADDR: begin
          addr_d  = req_i.write_data[RamAw-1:0];
          phase_d = PH_WR_DATA;
        end
        PH_WR_DATA: begin
          ram_wr_o.en = step_i;
          phase_d     = PH_IDLE;
        end
        default: ;
      endcase
    end else begin
      read_data_o = obuf_i;
      obf_d       = 1'b0;
    end

    if (!step_i) begin
      phase_d = phase_q;
      addr_d  = addr_q;
      obf_d   = obf_q;
    end
  end

endmodule

FILE: src/ehbm_mbox.sv
// ----------------------------------------------------------------------------
// Backlight mailbox
// Shadows the mailbox parameter bytes and acts on doorbell writes to update
// the backlight enable, brightness and zone colors.
// ----------------------------------------------------------------------------
module ehbm_mbox
  import ehbm_pkg::*;
(
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ram_wr_t                          ram_wr_i,
  output logic                             light_en_o,
  output logic [7:0]                       level_o,
  output logic [ZoneCount-1:0][ColorW-1:0] zone_o
);

  logic [7:0]                       p0_q, p1_q, p2_q, p3_q;
  logic                             light_en_q, light_en_d;
  logic [7:0]                       level_q, level_d;
  logic [ZoneCount-1:0][ColorW-1:0] zone_q, zone_d;
  logic                             doorbell;

  // Parameter bytes mirror RAM so the doorbell sees them without a read port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_q <= '0;
      p1_q <= '0;
      p2_q <= '0;
      p3_q <= '0;
    end else if (ram_wr_i.en) begin
      if (ram_wr_i.addr == AddrParam0) p0_q <= ram_wr_i.data;
      if (ram_wr_i.addr == AddrParam1) p1_q <= ram_wr_i.data;
      if (ram_wr_i.addr == AddrParam2) p2_q <= ram_wr_i.data;
      if (ram_wr_i.addr == AddrParam3) p3_q <= ram_wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_en_q <= 1'b0;
      level_q    <= '0;
      zone_q     <= '0;
    end else begin
      light_en_q <= light_en_d;
      level_q    <= level_d;
      zone_q     <= zone_d;
    end
  end

  assign doorbell = ram_wr_i.en && (ram_wr_i.addr == AddrDoorbell);

  always_comb begin
    light_en_d = light_en_q;
    level_d    = level_q;
    zone_d     = zone_q;
    if (doorbell) begin
      if (ram_wr_i.data == MbCmdPower && p0_q == MbSelPower) begin
        if (p1_q == MbPowerOn) begin
          light_en_d = 1'b1;
        end else if (p1_q == MbPowerOff) begin
          light_en_d = 1'b0;
        end
      end else if (ram_wr_i.data == MbCmdSet && light_en_q) begin
        // Color bytes arrive as blue, red, green; stored as red, green, blue.
        for (int z = 0; z < ZoneCount; z++) begin
          if (p0_q == MbSelZoneBase + 8'(z)) begin
            zone_d[z] = {p2_q, p3_q, p1_q};
          end
        end
        if (p0_q == MbSelLevel) begin
          level_d = p1_q;
        end
      end
    end
  end

  // Results report the state after this access.
  assign light_en_o = light_en_d;
  assign level_o    = level_d;
  assign zone_o     = zone_d;

endmodule

FILE: src/ec_host_port_backlight_mailbox_core.sv
// ----------------------------------------------------------------------------
// Host port backlight mailbox core
// Controller side of an embedded-controller host port with a backlight mailbox.
//
// Usage: each host access (port, read or write, byte) enters as one request on
// req_i; exactly one response leaves on rsp_o carrying the byte read (zero on
// writes) plus the backlight enable, brightness and three zone colors as they
// stand after that access. Both channels use a valid/ready handshake.
// The response is registered: the accepting edge loads the request register,
// and the edge at which the decode stage steps loads the result of the
// decode, RAM access and mailbox update into the response register.
// Throughput is one request per cycle while the receiver takes each response,
// set by the decode stage and the one-write, one-read RAM port.
// When the receiver stalls, the response register holds its result and the
// request register still takes one more request; only then does req_i.ready
// drop. Reset empties both registers, returns the host phase to idle, clears
// output-full, switches the backlight off, zeroes brightness and colors, and
// makes every RAM byte read as zero until written. No clearing pass is needed.
// ----------------------------------------------------------------------------
module ec_host_port_backlight_mailbox_core
  import ehbm_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  ehbm_req_if.sink       req_i,
  ehbm_rsp_if.source     rsp_o
);

  // Request register.
  logic      req_valid_q;
  host_req_t req_q;

  // Response register.
  logic        rsp_valid_q;
  logic [7:0]  rsp_read_data_q;
  logic        rsp_light_q;
  logic [7:0]  rsp_level_q;
  logic [2:0][ColorW-1:0] rsp_zone_q;

  logic       step;
  ram_wr_t    ram_wr;
  ram_rd_t    ram_rd;
  logic [7:0] obuf;
  logic [7:0] read_data;
  logic       light_en;
  logic [7:0] level;
  logic [ZoneCount-1:0][ColorW-1:0] zone;
  logic [2:0][ColorW-1:0]           zone_all;

  // The decode stage moves when it holds a request and the response register
  // is empty or being drained this cycle.
  assign step      = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.port_select <= req_i.port_select;
      req_q.func        <= req_i.func;
      req_q.write_data  <= req_i.write_data;
    end
  end

  ehbm_host u_host (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_i       (req_q),
    .obuf_i      (obuf),
    .ram_wr_o    (ram_wr),
    .ram_rd_o    (ram_rd),
    .read_data_o (read_data)
  );

  // The RAM read register is the output buffer: it only changes on an
  // address read, and a later data read sees the registered byte.
  ehbm_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (ram_wr),
    .rd_i      (ram_rd),
    .rd_data_o (obuf)
  );

  ehbm_mbox u_mbox (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ram_wr_i   (ram_wr),
    .light_en_o (light_en),
    .level_o    (level),
    .zone_o     (zone)
  );

  // Zones beyond the configured count report zero.
  for (genvar z = 0; z < 3; z++) begin : g_zone
    if (z < ZoneCount) begin : g_used
      assign zone_all[z] = zone[z];
    end else begin : g_unused
      assign zone_all[z] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (step) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      rsp_read_data_q <= read_data;
      rsp_light_q     <= light_en;
      rsp_level_q     <= level;
      rsp_zone_q      <= zone_all;
    end
  end

  assign rsp_o.valid        = rsp_valid_q;
  assign rsp_o.read_data    = rsp_read_data_q;
  assign rsp_o.backlight_on = rsp_light_q;
  assign rsp_o.brightness   = rsp_level_q;
  assign rsp_o.zone0_color  = rsp_zone_q[0];
  assign rsp_o.zone1_color  = rsp_zone_q[1];
  assign rsp_o.zone2_color  = rsp_zone_q[2];

endmodule

FILE: src/ehbm_checker.sv
// ----------------------------------------------------------------------------
// Host port backlight mailbox port checker
// Watches the top-level channels for stalls, orphan responses and light
// settings that change while the backlight is off.
// ----------------------------------------------------------------------------
`include "ec_host_port_backlight_mailbox_core_defines.svh"

module ehbm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [7:0]  rsp_read_data_i,
  input logic        rsp_backlight_on_i,
  input logic [7:0]  rsp_brightness_i,
  input logic [23:0] rsp_zone0_color_i,
  input logic [23:0] rsp_zone1_color_i,
  input logic [23:0] rsp_zone2_color_i
);

  logic        req_fire, rsp_fire;
  logic [1:0]  pending_q;
  logic        last_on_q;
  logic [7:0]  last_level_q;
  logic [23:0] last_zone0_q, last_zone1_q, last_zone2_q;
  logic        rsp_stall;
  logic        rsp_while_off;
  logic        level_kept;
  logic        zones_kept;

  assign req_fire = req_valid_i && req_ready_i;
  assign rsp_fire = rsp_valid_i && rsp_ready_i;

  // Requests taken but not yet answered; the core holds at most two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 2'(req_fire) - 2'(rsp_fire);
    end
  end

  // Last delivered light state; reset state matches the core's.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_on_q    <= 1'b0;
      last_level_q <= '0;
      last_zone0_q <= '0;
      last_zone1_q <= '0;
      last_zone2_q <= '0;
    end else if (rsp_fire) begin
      last_on_q    <= rsp_backlight_on_i;
      last_level_q <= rsp_brightness_i;
      last_zone0_q <= rsp_zone0_color_i;
      last_zone1_q <= rsp_zone1_color_i;
      last_zone2_q <= rsp_zone2_color_i;
    end
  end

  assign rsp_stall     = rsp_valid_i && !rsp_ready_i;
  assign rsp_while_off = rsp_valid_i && !last_on_q;
  assign level_kept    = (rsp_brightness_i == last_level_q);
  assign zones_kept    = (rsp_zone0_color_i == last_zone0_q) &&
                         (rsp_zone1_color_i == last_zone1_q) &&
                         (rsp_zone2_color_i == last_zone2_q);

  `EHBM_ASSERT_NEXT(a_rsp_hold, clk_i, rst_ni, rsp_stall, rsp_valid_i && $stable(rsp_read_data_i))
  `EHBM_ASSERT_NOW(a_no_orphan, clk_i, rst_ni, rsp_valid_i, pending_q != 2'd0)
  `EHBM_ASSERT_NOW(a_level_off, clk_i, rst_ni, rsp_while_off, level_kept)
  `EHBM_ASSERT_NOW(a_zone_off, clk_i, rst_ni, rsp_while_off, zones_kept)

endmodule

bind ec_host_port_backlight_mailbox_core ehbm_checker u_ehbm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .req_valid_i        (req_i.valid),
  .req_ready_i        (req_i.ready),
  .rsp_valid_i        (rsp_o.valid),
  .rsp_ready_i        (rsp_o.ready),
  .rsp_read_data_i    (rsp_o.read_data),
  .rsp_backlight_on_i (rsp_o.backlight_on),
  .rsp_brightness_i   (rsp_o.brightness),
  .rsp_zone0_color_i  (rsp_o.zone0_color),
  .rsp_zone1_color_i  (rsp_o.zone1_color),
  .rsp_zone2_color_i  (rsp_o.zone2_color)
);

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the host port backlight mailbox core
// Sends host port requests (status and data reads, commands, RAM accesses and
// mailbox doorbells) with random gaps on both channels. A scoreboard keeps its
// own model of the controller and compares every response field by field.
// ----------------------------------------------------------------------------
module tb;
  import ehbm_pkg::*;

  // Port and access codes of one host request.
  localparam logic PortData  = 1'b0;
  localparam logic PortCmd   = 1'b1;
  localparam logic HostRead  = 1'b0;
  localparam logic HostWrite = 1'b1;

  localparam int RandomItems = 1000;
  localparam int IdlePct     = 33;
  // Requests sent during this window run with no idling on either side.
  localparam int CalmStart   = 400;
  localparam int CalmLen     = 200;
  localparam int DrainCycles = 10;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              backlight_on;
    logic [7:0]        brightness;
    logic [ColorW-1:0] zone0;
    logic [ColorW-1:0] zone1;
    logic [ColorW-1:0] zone2;
  } host_rsp_t;

  // Shadow of the controller: host phase, RAM, output buffer and the backlight
  // state, plus the responses that are owed by the block in request order.
  class mailbox_scoreboard;
    host_phase_e       phase;
    logic [7:0]        addr_latch;
    logic [7:0]        out_buf;
    logic              out_full;
    logic [7:0]        ram [RamDepth];
    logic              light_on;
    logic [7:0]        level;
    logic [ColorW-1:0] zone [3];
    host_rsp_t         due_q [$];
    int                errors;

    function new();
      phase      = PH_IDLE;
      addr_latch = '0;
      out_buf    = '0;
      out_full   = 1'b0;
      foreach (ram[i]) ram[i] = '0;
      light_on   = 1'b0;
      level      = '0;
      foreach (zone[i]) zone[i] = '0;
      errors     = 0;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    // The mailbox acts on the command byte just stored at the doorbell address.
    function void ring_doorbell(logic [7:0] cmd);
      logic [7:0] sel;
      logic [7:0] arg;
      int         z;
      sel = ram[AddrParam0];
      arg = ram[AddrParam1];
      if (cmd == MbCmdPower) begin
        if (sel == MbSelPower) begin
          if (arg == MbPowerOn) light_on = 1'b1;
          else if (arg == MbPowerOff) light_on = 1'b0;
        end
      end else if (cmd == MbCmdSet && light_on) begin
        if (sel >= MbSelZoneBase && sel < MbSelLevel) begin
          z = int'(sel - MbSelZoneBase);
          // Colors are stored red, green, blue; the parameters come as B, R, G.
          if (z < ZoneCount) zone[z] = {ram[AddrParam2], ram[AddrParam3], arg};
        end else if (sel == MbSelLevel) begin
          level = arg;
        end
      end
    endfunction

    function void note_request(logic port, logic func, logic [7:0] d);
      host_rsp_t r;
      r = '0;
      if (port == PortCmd) begin
        if (func == HostWrite) begin
          if (d == CmdRead) phase = PH_RD_ADDR;
          else if (d == CmdWrite) phase = PH_WR_ADDR;
          else phase = PH_IDLE;
        end else begin
          // Status read: input full always reads back as zero.
          r.read_data = out_full ? StatObf : 8'h00;
        end
      end else if (func == HostWrite) begin
        case (phase)
          PH_RD_ADDR: begin
            out_buf  = ram[d];
            out_full = 1'b1;
            phase    = PH_IDLE;
          end
          PH_WR_ADDR: begin
            addr_latch = d;
            phase      = PH_WR_DATA;
          end
          PH_WR_DATA: begin
            ram[addr_latch] = d;
            phase           = PH_IDLE;
            if (addr_latch == AddrDoorbell) ring_doorbell(d);
          end
          default: ;
        endcase
      end else begin
        r.read_data = out_buf;
        out_full    = 1'b0;
      end
      r.backlight_on = light_on;
      r.brightness   = level;
      r.zone0        = (ZoneCount > 0) ? zone[0] : '0;
      r.zone1        = (ZoneCount > 1) ? zone[1] : '0;
      r.zone2        = (ZoneCount > 2) ? zone[2] : '0;
      due_q.push_back(r);
    endfunction

    function void field_diff(string name, logic [23:0] want, logic [23:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_response(host_rsp_t got);
      host_rsp_t want;
      if (due_q.size() == 0) begin
        $display("%0t: response with none expected: expected nothing, actual %h",
                 $time, got);
        errors++;
        return;
      end
      want = due_q.pop_front();
      field_diff("read_data",    24'(want.read_data),    24'(got.read_data));
      field_diff("backlight_on", 24'(want.backlight_on), 24'(got.backlight_on));
      field_diff("brightness",   24'(want.brightness),   24'(got.brightness));
      field_diff("zone0_color",  want.zone0,             got.zone0);
      field_diff("zone1_color",  want.zone1,             got.zone1);
      field_diff("zone2_color",  want.zone2,             got.zone2);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   sent;

  ehbm_req_if req_if ();
  ehbm_rsp_if rsp_if ();

  mailbox_scoreboard sb = new();

  ec_host_port_backlight_mailbox_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case a handshake never completes.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Offers one request from a falling edge and holds it until it is taken.
  // Returns at the falling edge after acceptance, so back-to-back requests keep
  // valid high without a gap.
  task automatic send_req(logic port, logic func, logic [7:0] data);
    calm = (sent >= CalmStart) && (sent < CalmStart + CalmLen);
    while (!calm && $urandom_range(99) < IdlePct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid       = 1'b1;
    req_if.port_select = port;
    req_if.func        = func;
    req_if.write_data  = data;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_request(port, func, data);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic ram_write(logic [7:0] addr, logic [7:0] data);
    send_req(PortCmd, HostWrite, CmdWrite);
    send_req(PortData, HostWrite, addr);
    send_req(PortData, HostWrite, data);
  endtask

  task automatic ram_read(logic [7:0] addr);
    send_req(PortCmd, HostWrite, CmdRead);
    send_req(PortData, HostWrite, addr);
  endtask

  // Loads the mailbox parameters, then rings the doorbell with cmd.
  task automatic mb_doorbell(logic [7:0] cmd, logic [7:0] sel, logic [7:0] arg,
                             logic [7:0] red, logic [7:0] green, bit with_color);
    ram_write(8'(AddrParam0), sel);
    ram_write(8'(AddrParam1), arg);
    if (with_color) begin
      ram_write(8'(AddrParam2), red);
      ram_write(8'(AddrParam3), green);
    end
    ram_write(8'(AddrDoorbell), cmd);
  endtask

  // Response side: ready is redrawn at every falling edge and results are
  // taken at the rising edge.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_if.ready = calm || ($urandom_range(99) >= IdlePct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      sb.check_response({rsp_if.read_data, rsp_if.backlight_on, rsp_if.brightness,
                         rsp_if.zone0_color, rsp_if.zone1_color, rsp_if.zone2_color});
    end
  end

  initial begin
    logic [7:0] sel;
    logic [7:0] arg;
    logic [7:0] cmd;
    int         n;
    int         stop_at;

    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.port_select = PortData;
    req_if.func        = HostRead;
    req_if.write_data  = 8'h00;
    sent               = 0;
    calm               = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Status and data read straight out of reset, then a data
    // write while idle and an unknown command, both of which are ignored.
    send_req(PortCmd, HostRead, 8'h00);
    send_req(PortData, HostRead, 8'h00);
    send_req(PortData, HostWrite, 8'hFF);
    send_req(PortCmd, HostWrite, 8'hFF);
    // Write the lowest RAM byte with all ones and read it back.
    ram_write(8'h00, 8'hFF);
    ram_read(8'h00);
    send_req(PortCmd, HostRead, 8'h00);
    send_req(PortData, HostRead, 8'h00);
    // A read command abandons a pending write; the top byte reads as zero.
    send_req(PortCmd, HostWrite, CmdWrite);
    ram_read(8'hFF);
    send_req(PortData, HostRead, 8'h00);
    // A set command while the backlight is off must be ignored.
    ram_write(8'(AddrParam0), MbSelLevel);
    ram_write(8'(AddrParam1), 8'hFF);
    ram_write(8'(AddrDoorbell), MbCmdSet);

    // Random part: mostly well-formed RAM and mailbox sequences, with some
    // noise and broken sequences mixed in.
    stop_at = sent + RandomItems;
    while (sent < stop_at) begin
      case ($urandom_range(10))
        0, 1: begin
          sel = ($urandom_range(9) == 0) ? rand_byte() : MbSelPower;
          cmd = ($urandom_range(9) == 0) ? rand_byte() : MbCmdPower;
          case ($urandom_range(4))
            0, 1, 2: arg = MbPowerOn;
            3:       arg = MbPowerOff;
            default: arg = rand_byte();
          endcase
          mb_doorbell(cmd, sel, arg, 8'h00, 8'h00, 1'b0);
        end
        2, 3, 4: begin
          sel = ($urandom_range(7) == 0) ? rand_byte()
                                         : MbSelZoneBase + 8'($urandom_range(ZoneCount - 1));
          cmd = ($urandom_range(9) == 0) ? rand_byte() : MbCmdSet;
          mb_doorbell(cmd, sel, rand_byte(), rand_byte(), rand_byte(), 1'b1);
        end
        5: begin
          cmd = ($urandom_range(9) == 0) ? rand_byte() : MbCmdSet;
          mb_doorbell(cmd, MbSelLevel, rand_byte(), 8'h00, 8'h00, 1'b0);
        end
        6: begin
          if ($urandom_range(3) == 0) ram_write(8'(AddrDoorbell) + 8'($urandom_range(4)),
                                                rand_byte());
          else ram_write(rand_byte(), rand_byte());
        end
        7: begin
          if ($urandom_range(3) == 0) ram_read(8'(AddrDoorbell) + 8'($urandom_range(4)));
          else ram_read(rand_byte());
          send_req(PortCmd, HostRead, rand_byte());
          send_req(PortData, HostRead, rand_byte());
        end
        8: begin
          n = $urandom_range(1, 3);
          repeat (n) send_req(1'($urandom), 1'($urandom), rand_byte());
        end
        9: begin
          // Start a sequence, maybe poll in the middle, then break it off.
          send_req(PortCmd, HostWrite, $urandom_range(1) ? CmdWrite : CmdRead);
          if ($urandom_range(1)) send_req(PortData, HostWrite, rand_byte());
          if ($urandom_range(1)) send_req(PortCmd, HostRead, rand_byte());
          if ($urandom_range(1)) send_req(PortData, HostRead, rand_byte());
          send_req(PortCmd, HostWrite, $urandom_range(1) ? CmdRead : rand_byte());
        end
        default: begin
          send_req(PortCmd, HostRead, rand_byte());
          send_req(PortData, HostRead, rand_byte());
        end
      endcase
    end
    req_if.valid = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
